>>> hw/rtl/rtund_pkg.sv
// rtund_pkg: shared types, constants and fixed-point helpers for the
// radial-tangential undistortion block; no dependencies
`timescale 1ns / 1ps

package rtund_pkg;

	localparam int MAX_ITERATIONS = 15;
	localparam int PIX_FRAC = 4;
	localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

	localparam int Q_FRAC = 28;
	localparam logic signed [39:0] Q_ONE = 40'sd268435456;
	localparam logic signed [39:0] Q_MAX = 40'sd2147483647;
	localparam logic signed [39:0] Q_MIN = -40'sd2147483648;
	localparam logic [63:0] CHI2_CONVERGED = 64'd7205759403793;
	localparam logic [63:0] CHI2_DONE = 64'd73;

	localparam int PIX_SHIFT = Q_FRAC + 8 - PIX_FRAC;
	localparam int DIFF_W = 26;

	localparam int DIV_W = 60;
	localparam int DIVS_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	typedef enum logic [2:0] {
		CFG_FOCAL_U, CFG_FOCAL_V, CFG_CENTER_U, CFG_CENTER_V,
		CFG_RADIAL_K1, CFG_RADIAL_K2, CFG_TANG_P1, CFG_TANG_P2
	} cfg_idx_t;

	typedef enum logic [5:0] {
		UOP_MX, UOP_MY, UOP_MXY, UOP_RHO, UOP_RPXY, UOP_RHO2, UOP_KR1, UOP_KR2,
		UOP_RAD, UOP_XR, UOP_P1M, UOP_P2R, UOP_YR, UOP_P2M, UOP_P1R, UOP_K1MX,
		UOP_RMX, UOP_K2RMX, UOP_P1Y, UOP_P2X, UOP_K1MXY, UOP_RMXY, UOP_K2RMXY,
		UOP_P1X, UOP_P2Y, UOP_K1MY, UOP_RMY, UOP_K2RMY, UOP_SUMS, UOP_ERR,
		UOP_JJ, UOP_JO, UOP_EXX, UOP_EYY, UOP_DET, UOP_A1, UOP_A2, UOP_A3,
		UOP_A4, UOP_NXY
	} uop_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NU_GO, ST_NU_WAIT, ST_NV_GO, ST_NV_WAIT, ST_MUL, ST_WB,
		ST_DX_GO, ST_DX_WAIT, ST_DY_GO, ST_DY_WAIT, ST_NEXT, ST_PIX_MUL,
		ST_PIX_WB, ST_EMIT
	} state_t;

	typedef struct packed {
		logic [15:0] pixel_u;
		logic [15:0] pixel_v;
	} pix_item_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > Q_MAX) r = Q_MAX[31:0];
		else if (v < Q_MIN) r = Q_MIN[31:0];
		else r = v[31:0];
		return r;
	endfunction

	// product back to q4.28, round half away from zero, saturate
	function automatic logic signed [31:0] qround(input logic signed [63:0] p);
		logic [63:0] m;
		logic signed [39:0] r;
		m = p[63] ? 64'(-p) : 64'(p);
		m = (m + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
		r = $signed({1'b0, m[38:0]});
		if (p[63]) r = -r;
		return sat32(r);
	endfunction

	// signed quotient from magnitude, saturated to 32 bits
	function automatic logic signed [31:0] qsat(input logic [DIV_W-1:0] q, input logic neg);
		logic signed [32:0] r;
		r = $signed({1'b0, q[31:0]});
		if (neg) r = -r;
		if (!neg && q > 60'd2147483647) return Q_MAX[31:0];
		if (neg && q > 60'd2147483648) return Q_MIN[31:0];
		return r[31:0];
	endfunction

endpackage

>>> hw/rtl/radtan_point_undistort_gauss_newton_top.sv
// sequence: take the request, normalize (two 60-bit serial divides), then per gauss-newton
// step run the products on the shared multiplier, the two update divides (skipped on a
// singular jacobian) and the close of the step, up to 15 steps, then map back to pixels;
// one request at a time
// throughput: one result per full solve, set by the single multiplier and serial divider
// reset: arst_n clears the queue and sequencer and loads the default focal/center/coefs
`timescale 1ns / 1ps

module radtan_point_undistort_gauss_newton_top
	import rtund_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        pixel_u,
	input  logic [15:0]        pixel_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] corrected_u,
	output logic signed [17:0] corrected_v,
	output logic               converged,
	output logic               saturated
);

	pix_item_t in_item, head_item;
	logic      head_valid, head_pop;

	assign in_item.pixel_u = pixel_u;
	assign in_item.pixel_v = pixel_v;

	rtund_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_pop   (head_pop)
	);

	rtund_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.head_pop    (head_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.corrected_u (corrected_u),
		.corrected_v (corrected_v),
		.converged   (converged),
		.saturated   (saturated)
	);

endmodule

>>> hw/rtl/rtund_front.sv
// rtund_front: two-entry request queue in front of the solver
// depends on rtund_pkg
`timescale 1ns / 1ps

module rtund_front
	import rtund_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  pix_item_t in_item,
	output logic      head_valid,
	output pix_item_t head_item,
	input  logic      head_pop
);

	pix_item_t  slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_ready   = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];
	assign push       = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (head_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, head_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/rtund_div.sv
// rtund_div: restoring unsigned divider, one quotient bit per cycle
// depends on rtund_pkg
`timescale 1ns / 1ps

module rtund_div
	import rtund_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0]    rem_q, dvs_q;
	logic [DIV_W-1:0]     work_q;
	logic [DIVS_W:0]      shifted, diff;
	logic                 ge;

	assign shifted = {rem_q, work_q[DIV_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	assign rsp.done     = done_q;
	assign rsp.quotient = work_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dvs_q  <= req.divisor;
			work_q <= req.dividend;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
			work_q <= {work_q[DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> hw/rtl/rtund_back.sv
// rtund_back: config registers and the gauss-newton sequencer with one shared
// multiplier and the divider; depends on rtund_pkg and rtund_div
`timescale 1ns / 1ps

module rtund_back
	import rtund_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [19:0]        cfg_data,
	input  logic               head_valid,
	input  pix_item_t          head_item,
	output logic               head_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] corrected_u,
	output logic signed [17:0] corrected_v,
	output logic               converged,
	output logic               saturated
);

	logic [19:0] focal_u_q, focal_v_q, center_u_q, center_v_q;
	logic [17:0] k1_raw_q, k2_raw_q, p1_raw_q, p2_raw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_u_q  <= 20'd131072;
			focal_v_q  <= 20'd131072;
			center_u_q <= 20'd81920;
			center_v_q <= 20'd61440;
			k1_raw_q   <= '0;
			k2_raw_q   <= '0;
			p1_raw_q   <= '0;
			p2_raw_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_FOCAL_U:   focal_u_q  <= cfg_data;
				CFG_FOCAL_V:   focal_v_q  <= cfg_data;
				CFG_CENTER_U:  center_u_q <= cfg_data;
				CFG_CENTER_V:  center_v_q <= cfg_data;
				CFG_RADIAL_K1: k1_raw_q   <= cfg_data[17:0];
				CFG_RADIAL_K2: k2_raw_q   <= cfg_data[17:0];
				CFG_TANG_P1:   p1_raw_q   <= cfg_data[17:0];
				CFG_TANG_P2:   p2_raw_q   <= cfg_data[17:0];
			endcase
		end
	end

	logic signed [31:0] k1, k2, p1, p2;
	logic [19:0] feff_u, feff_v;

	// coefficients q2.16 moved to q4.28
	assign k1 = $signed({{2{k1_raw_q[17]}}, k1_raw_q, 12'd0});
	assign k2 = $signed({{2{k2_raw_q[17]}}, k2_raw_q, 12'd0});
	assign p1 = $signed({{2{p1_raw_q[17]}}, p1_raw_q, 12'd0});
	assign p2 = $signed({{2{p2_raw_q[17]}}, p2_raw_q, 12'd0});
	assign feff_u = (focal_u_q == 20'd0) ? 20'd1 : focal_u_q;
	assign feff_v = (focal_v_q == 20'd0) ? 20'd1 : focal_v_q;

	state_t state_q, state_d;
	uop_t   uop_q;
	logic [ITER_W-1:0] it_q;
	logic   ax_q, neg_q, conv_q, sat_u_q, sat_v_q;
	logic   out_valid_q;
	logic [15:0] pu_q, pv_q;
	logic signed [17:0] cu_q, cv_q, out_u_q, out_v_q;
	logic   out_conv_q, out_sat_q;

	logic signed [31:0] x_q, y_q, tu_q, tv_q;
	logic signed [31:0] mx_q, my_q, mxy_q, rho_q, rpx_q, rpy_q, rho2_q, kr1_q, kr2_q, rad_q;
	logic signed [31:0] xr_q, p1m_q, p2r_q, yr_q, p2m_q, p1r_q;
	logic signed [31:0] k1mx_q, rmx_q, k2rmx_q, p1y_q, p2x_q;
	logic signed [31:0] k1mxy_q, rmxy_q, k2rmxy_q, p1x_q, p2y_q;
	logic signed [31:0] k1my_q, rmy_q, k2rmy_q;
	logic signed [31:0] du0_q, du1_q, j00_q, j01_q, j11_q, ex_q, ey_q;
	logic signed [31:0] jj_q, jo_q, det_q, a1_q, a2_q, a3_q, a4_q, nx_q, ny_q;
	logic [63:0] exx_q, eyy_q, chi2_q;

	logic signed [31:0] mul_a, mul_b, qr, qs;
	logic signed [63:0] prod_s1;

	div_req_t dreq;
	div_rsp_t drsp;

	rtund_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// normalization operands
	logic signed [DIFF_W-1:0] diff_u, diff_v;
	logic [DIFF_W-1:0] mag_u, mag_v;
	logic [31:0] nx_mag, ny_mag, det_mag;

	assign diff_u = $signed((DIFF_W'(pu_q) << (8 - PIX_FRAC)) - DIFF_W'(center_u_q));
	assign diff_v = $signed((DIFF_W'(pv_q) << (8 - PIX_FRAC)) - DIFF_W'(center_v_q));
	assign mag_u  = diff_u[DIFF_W-1] ? DIFF_W'(-diff_u) : DIFF_W'(diff_u);
	assign mag_v  = diff_v[DIFF_W-1] ? DIFF_W'(-diff_v) : DIFF_W'(diff_v);
	assign nx_mag  = nx_q[31] ? 32'(-nx_q) : 32'(nx_q);
	assign ny_mag  = ny_q[31] ? 32'(-ny_q) : 32'(ny_q);
	assign det_mag = det_q[31] ? 32'(-det_q) : 32'(det_q);

	assign qr = qround(prod_s1);
	assign qs = qsat(drsp.quotient, neg_q);

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		unique case (state_q)
			ST_NU_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = (DIV_W'(mag_u) << Q_FRAC) + DIV_W'(feff_u >> 1);
				dreq.divisor  = DIVS_W'(feff_u);
			end
			ST_NV_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = (DIV_W'(mag_v) << Q_FRAC) + DIV_W'(feff_v >> 1);
				dreq.divisor  = DIVS_W'(feff_v);
			end
			ST_DX_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(nx_mag) << Q_FRAC;
				dreq.divisor  = det_mag;
			end
			ST_DY_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = DIV_W'(ny_mag) << Q_FRAC;
				dreq.divisor  = det_mag;
			end
			default: ;
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = x_q;
		mul_b = x_q;
		if (state_q == ST_PIX_MUL) begin
			mul_a = ax_q ? y_q : x_q;
			mul_b = $signed({12'd0, ax_q ? feff_v : feff_u});
		end else begin
			unique case (uop_q)
				UOP_MX:     begin mul_a = x_q;   mul_b = x_q;    end
				UOP_MY:     begin mul_a = y_q;   mul_b = y_q;    end
				UOP_MXY:    begin mul_a = x_q;   mul_b = y_q;    end
				UOP_RHO2:   begin mul_a = rho_q; mul_b = rho_q;  end
				UOP_KR1:    begin mul_a = k1;    mul_b = rho_q;  end
				UOP_KR2:    begin mul_a = k2;    mul_b = rho2_q; end
				UOP_XR:     begin mul_a = x_q;   mul_b = rad_q;  end
				UOP_P1M:    begin mul_a = p1;    mul_b = mxy_q;  end
				UOP_P2R:    begin mul_a = p2;    mul_b = rpx_q;  end
				UOP_YR:     begin mul_a = y_q;   mul_b = rad_q;  end
				UOP_P2M:    begin mul_a = p2;    mul_b = mxy_q;  end
				UOP_P1R:    begin mul_a = p1;    mul_b = rpy_q;  end
				UOP_K1MX:   begin mul_a = k1;    mul_b = mx_q;   end
				UOP_RMX:    begin mul_a = rho_q; mul_b = mx_q;   end
				UOP_K2RMX:  begin mul_a = k2;    mul_b = rmx_q;  end
				UOP_P1Y:    begin mul_a = p1;    mul_b = y_q;    end
				UOP_P2X:    begin mul_a = p2;    mul_b = x_q;    end
				UOP_K1MXY:  begin mul_a = k1;    mul_b = mxy_q;  end
				UOP_RMXY:   begin mul_a = rho_q; mul_b = mxy_q;  end
				UOP_K2RMXY: begin mul_a = k2;    mul_b = rmxy_q; end
				UOP_P1X:    begin mul_a = p1;    mul_b = x_q;    end
				UOP_P2Y:    begin mul_a = p2;    mul_b = y_q;    end
				UOP_K1MY:   begin mul_a = k1;    mul_b = my_q;   end
				UOP_RMY:    begin mul_a = rho_q; mul_b = my_q;   end
				UOP_K2RMY:  begin mul_a = k2;    mul_b = rmy_q;  end
				UOP_JJ:     begin mul_a = j00_q; mul_b = j11_q;  end
				UOP_JO:     begin mul_a = j01_q; mul_b = j01_q;  end
				UOP_EXX:    begin mul_a = ex_q;  mul_b = ex_q;   end
				UOP_EYY:    begin mul_a = ey_q;  mul_b = ey_q;   end
				UOP_A1:     begin mul_a = j11_q; mul_b = ex_q;   end
				UOP_A2:     begin mul_a = j01_q; mul_b = ey_q;   end
				UOP_A3:     begin mul_a = j00_q; mul_b = ey_q;   end
				UOP_A4:     begin mul_a = j01_q; mul_b = ex_q;   end
				default: ;
			endcase
		end
	end

	// pixel mapping: focal*x + center, rounded and clipped to 18 bits
	logic signed [63:0] pix_sum;
	logic [63:0] pix_mag;
	logic        pix_neg, pix_clip;
	logic signed [18:0] pix_r;
	logic signed [17:0] pix_val;

	always_comb begin
		pix_sum = prod_s1 + (64'(ax_q ? center_v_q : center_u_q) << Q_FRAC);
		pix_neg = pix_sum[63];
		pix_mag = pix_neg ? 64'(-pix_sum) : 64'(pix_sum);
		pix_mag = (pix_mag + (64'd1 << (PIX_SHIFT - 1))) >> PIX_SHIFT;
		pix_r   = $signed({1'b0, pix_mag[17:0]});
		if (pix_neg) pix_r = -pix_r;
		pix_clip = 1'b0;
		pix_val  = pix_r[17:0];
		if (!pix_neg && pix_mag > 64'd131071) begin
			pix_clip = 1'b1;
			pix_val  = 18'sh1FFFF;
		end else if (pix_neg && pix_mag > 64'd131072) begin
			pix_clip = 1'b1;
			pix_val  = -18'sh20000;
		end
	end

	logic iter_last, stop_now;
	assign iter_last = (it_q == ITER_W'(MAX_ITERATIONS - 1));
	assign stop_now  = (chi2_q < CHI2_DONE) || iter_last;

	always_comb begin
		state_d  = state_q;
		head_pop = 1'b0;
		unique case (state_q)
			ST_IDLE: if (head_valid) begin
				head_pop = 1'b1;
				state_d  = ST_NU_GO;
			end
			ST_NU_GO:   state_d = ST_NU_WAIT;
			ST_NU_WAIT: if (drsp.done) state_d = ST_NV_GO;
			ST_NV_GO:   state_d = ST_NV_WAIT;
			ST_NV_WAIT: if (drsp.done) state_d = ST_MUL;
			ST_MUL:     state_d = ST_WB;
			ST_WB: begin
				if (uop_q == UOP_NXY) state_d = (det_q != 32'sd0) ? ST_DX_GO : ST_NEXT;
				else state_d = ST_MUL;
			end
			ST_DX_GO:   state_d = ST_DX_WAIT;
			ST_DX_WAIT: if (drsp.done) state_d = ST_DY_GO;
			ST_DY_GO:   state_d = ST_DY_WAIT;
			ST_DY_WAIT: if (drsp.done) state_d = ST_NEXT;
			ST_NEXT:    state_d = stop_now ? ST_PIX_MUL : ST_MUL;
			ST_PIX_MUL: state_d = ST_PIX_WB;
			ST_PIX_WB:  state_d = ax_q ? ST_EMIT : ST_PIX_MUL;
			ST_EMIT:    if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uop_q       <= UOP_MX;
			it_q        <= '0;
			ax_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					uop_q <= UOP_MX;
					it_q  <= '0;
					ax_q  <= 1'b0;
				end
				ST_WB: if (uop_q != UOP_NXY) uop_q <= uop_t'(uop_q + 6'd1);
				ST_NEXT: begin
					uop_q <= UOP_MX;
					if (!stop_now) it_q <= it_q + 1'b1;
				end
				ST_PIX_WB: ax_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		unique case (state_q)
			ST_IDLE: begin
				pu_q   <= head_item.pixel_u;
				pv_q   <= head_item.pixel_v;
				conv_q <= 1'b0;
			end
			ST_NU_GO: neg_q <= diff_u[DIFF_W-1];
			ST_NU_WAIT: if (drsp.done) begin
				tu_q <= qs;
				x_q  <= qs;
			end
			ST_NV_GO: neg_q <= diff_v[DIFF_W-1];
			ST_NV_WAIT: if (drsp.done) begin
				tv_q <= qs;
				y_q  <= qs;
			end
			ST_WB: begin
				unique case (uop_q)
					UOP_MX:     mx_q     <= qr;
					UOP_MY:     my_q     <= qr;
					UOP_MXY:    mxy_q    <= qr;
					UOP_RHO:    rho_q    <= sat32(40'(mx_q) + 40'(my_q));
					UOP_RPXY: begin
						rpx_q <= sat32(40'(rho_q) + 2 * 40'(mx_q));
						rpy_q <= sat32(40'(rho_q) + 2 * 40'(my_q));
					end
					UOP_RHO2:   rho2_q   <= qr;
					UOP_KR1:    kr1_q    <= qr;
					UOP_KR2:    kr2_q    <= qr;
					UOP_RAD:    rad_q    <= sat32(40'(kr1_q) + 40'(kr2_q));
					UOP_XR:     xr_q     <= qr;
					UOP_P1M:    p1m_q    <= qr;
					UOP_P2R:    p2r_q    <= qr;
					UOP_YR:     yr_q     <= qr;
					UOP_P2M:    p2m_q    <= qr;
					UOP_P1R:    p1r_q    <= qr;
					UOP_K1MX:   k1mx_q   <= qr;
					UOP_RMX:    rmx_q    <= qr;
					UOP_K2RMX:  k2rmx_q  <= qr;
					UOP_P1Y:    p1y_q    <= qr;
					UOP_P2X:    p2x_q    <= qr;
					UOP_K1MXY:  k1mxy_q  <= qr;
					UOP_RMXY:   rmxy_q   <= qr;
					UOP_K2RMXY: k2rmxy_q <= qr;
					UOP_P1X:    p1x_q    <= qr;
					UOP_P2Y:    p2y_q    <= qr;
					UOP_K1MY:   k1my_q   <= qr;
					UOP_RMY:    rmy_q    <= qr;
					UOP_K2RMY:  k2rmy_q  <= qr;
					UOP_SUMS: begin
						du0_q <= sat32(40'(x_q) + 40'(xr_q) + 2 * 40'(p1m_q) + 40'(p2r_q));
						du1_q <= sat32(40'(y_q) + 40'(yr_q) + 2 * 40'(p2m_q) + 40'(p1r_q));
						j00_q <= sat32(Q_ONE + 40'(rad_q) + 2 * 40'(k1mx_q) + 4 * 40'(k2rmx_q)
							+ 2 * 40'(p1y_q) + 6 * 40'(p2x_q));
						j01_q <= sat32(2 * 40'(k1mxy_q) + 4 * 40'(k2rmxy_q)
							+ 2 * 40'(p1x_q) + 2 * 40'(p2y_q));
						j11_q <= sat32(Q_ONE + 40'(rad_q) + 2 * 40'(k1my_q) + 4 * 40'(k2rmy_q)
							+ 6 * 40'(p1y_q) + 2 * 40'(p2x_q));
					end
					UOP_ERR: begin
						ex_q <= sat32(40'(tu_q) - 40'(du0_q));
						ey_q <= sat32(40'(tv_q) - 40'(du1_q));
					end
					UOP_JJ:     jj_q  <= qr;
					UOP_JO:     jo_q  <= qr;
					UOP_EXX:    exx_q <= prod_s1;
					UOP_EYY:    eyy_q <= prod_s1;
					UOP_DET: begin
						det_q  <= sat32(40'(jj_q) - 40'(jo_q));
						chi2_q <= exx_q + eyy_q;
					end
					UOP_A1:     a1_q <= qr;
					UOP_A2:     a2_q <= qr;
					UOP_A3:     a3_q <= qr;
					UOP_A4:     a4_q <= qr;
					UOP_NXY: begin
						nx_q <= sat32(40'(a1_q) - 40'(a2_q));
						ny_q <= sat32(40'(a3_q) - 40'(a4_q));
						if (chi2_q < CHI2_CONVERGED) conv_q <= 1'b1;
					end
					default: ;
				endcase
			end
			ST_DX_GO: neg_q <= nx_q[31] ^ det_q[31];
			ST_DX_WAIT: if (drsp.done) x_q <= sat32(40'(x_q) + 40'(qs));
			ST_DY_GO: neg_q <= ny_q[31] ^ det_q[31];
			ST_DY_WAIT: if (drsp.done) y_q <= sat32(40'(y_q) + 40'(qs));
			ST_PIX_WB: begin
				if (ax_q) begin
					cv_q    <= pix_val;
					sat_v_q <= pix_clip;
				end else begin
					cu_q    <= pix_val;
					sat_u_q <= pix_clip;
				end
			end
			ST_EMIT: if (!out_valid_q || out_ready) begin
				out_u_q    <= cu_q;
				out_v_q    <= cv_q;
				out_conv_q <= conv_q;
				out_sat_q  <= sat_u_q | sat_v_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign corrected_u = out_u_q;
	assign corrected_v = out_v_q;
	assign converged   = out_conv_q;
	assign saturated   = out_sat_q;

endmodule
